/* src/tccp_pkg.sv */
// shared types and constants for the text console command parser
package tccp_pkg;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_CMD    = 2'd1,
        PH_ARGS   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ACT_GLYPH     = 2'd0,
        ACT_CLR_EOL   = 2'd1,
        ACT_CLR_LINE  = 2'd2,
        ACT_CLR_SCRN  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_DEFAULT_COLOR = 2'd0,
        REG_COLUMNS       = 2'd1,
        REG_ROWS          = 2'd2,
        REG_SCROLL_OFFSET = 2'd3
    } cfg_reg_t;

    localparam logic [7:0] CH_CMD_START = 8'h01;
    localparam logic [7:0] CH_CMD_END   = 8'h02;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0a;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CMD_COLOR    = 8'h63;
    localparam logic [7:0] CMD_RESET_C  = 8'h72;
    localparam logic [7:0] CMD_UP       = 8'h75;
    localparam logic [7:0] CMD_DOWN     = 8'h64;
    localparam logic [7:0] CMD_POS      = 8'h70;
    localparam logic [7:0] CMD_CLR_EOL  = 8'h6b;
    localparam logic [7:0] CMD_CLR_LINE = 8'h4b;
    localparam logic [7:0] CMD_CLR_SCRN = 8'h73;

    localparam logic [8:0]  TAB_MASK   = ~9'd7;
    localparam logic [15:0] ROW_MAX    = 16'hffff;
    localparam logic [31:0] COLOR_INIT = 32'hffff_ffff;
    localparam int          ARG_KEEP   = 4;

    typedef struct packed {
        logic       op;
        logic [7:0] text_byte;
        logic       end_of_buffer;
    } in_word_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  cell_col;
        logic [7:0]  cell_row;
        logic [7:0]  glyph;
        logic [31:0] glyph_color;
    } out_word_t;

endpackage

/* src/text_console_command_parser_unit.sv */
// top level of the text console command parser
//
//  channel  | signals                          | direction | notes
//  text     | text_valid text_ready text_data  | in        | one byte or frame start per word
//  act      | act_valid act_ready act_data     | out       | at most one draw or clear word per input
//  cfg      | cfg_we cfg_index cfg_data        | in        | register write, no wait
//
//  each input word goes from acceptance to its result through the input register,
//  then one pass of cursor and parser logic into the output register
//  one word per cycle sustained; the output register stalls the input register only
//  while a result is held and act_ready is low
//  reset clears the cursor, parser and color at once; no clearing pass
module text_console_command_parser_unit
    import tccp_pkg::*;
#(
    parameter int MAX_ARGS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  in_word_t   text_data,
    output logic       act_valid,
    input  logic       act_ready,
    output out_word_t  act_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_ARGS + 1);

    logic [31:0] default_color_reg;
    logic [7:0]  columns_reg;
    logic [7:0]  rows_reg;
    logic [15:0] scroll_offset_reg;

    logic        s1_valid_reg;
    in_word_t    s1_word_reg;
    logic        act_valid_reg;
    out_word_t   act_word_reg;
    logic        s1_go;

    logic [7:0]  col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [31:0] color_reg, color_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  arg_reg  [ARG_KEEP];
    logic [7:0]  arg_next [ARG_KEEP];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic        res_valid;
    out_word_t   res_word;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= COLOR_INIT;
            columns_reg       <= 8'd80;
            rows_reg          <= 8'd25;
            scroll_offset_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEFAULT_COLOR: default_color_reg <= cfg_data;
                REG_COLUMNS:       columns_reg       <= cfg_data[7:0];
                REG_ROWS:          rows_reg          <= cfg_data[7:0];
                REG_SCROLL_OFFSET: scroll_offset_reg <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // handshake
    assign s1_go      = s1_valid_reg && (!act_valid_reg || act_ready);
    assign text_ready = !s1_valid_reg || s1_go;
    assign act_valid  = act_valid_reg;
    assign act_data   = act_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            act_valid_reg <= 1'b0;
        end
        else
        begin
            if (text_ready)
            begin
                s1_valid_reg <= text_valid;
            end
            if (s1_go)
            begin
                act_valid_reg <= res_valid;
            end
            else if (act_ready)
            begin
                act_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            s1_word_reg <= text_data;
        end
        if (s1_go && res_valid)
        begin
            act_word_reg <= res_word;
        end
    end

    // cursor and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= 8'd0;
            row_reg   <= 16'd0;
            color_reg <= COLOR_INIT;
            phase_reg <= PH_NORMAL;
            code_reg  <= 8'd0;
            cnt_reg   <= '0;
            for (int i = 0; i < ARG_KEEP; i++)
            begin
                arg_reg[i] <= 8'd0;
            end
        end
        else if (s1_go)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            color_reg <= color_next;
            phase_reg <= phase_next;
            code_reg  <= code_next;
            cnt_reg   <= cnt_next;
            for (int i = 0; i < ARG_KEEP; i++)
            begin
                arg_reg[i] <= arg_next[i];
            end
        end
    end

    always_comb
    begin
        logic [7:0]  b;
        logic        eob;
        logic        run;
        logic        store;
        logic        visible;
        logic [16:0] row_diff;
        logic [16:0] row_sum;
        logic [8:0]  col_inc;
        logic [8:0]  col_tab;
        logic [7:0]  vrow;

        b     = s1_word_reg.text_byte;
        eob   = s1_word_reg.end_of_buffer;
        run   = 1'b0;
        store = 1'b0;

        row_diff = {1'b0, row_reg} - {1'b0, scroll_offset_reg};
        visible  = !row_diff[16] && (row_diff[15:0] < {8'd0, rows_reg});
        vrow     = row_diff[7:0];
        row_sum  = {1'b0, row_reg} + 17'd1;
        col_inc  = {1'b0, col_reg} + 9'd1;
        col_tab  = ({1'b0, col_reg} + 9'd8) & TAB_MASK;

        col_next   = col_reg;
        row_next   = row_reg;
        color_next = color_reg;
        phase_next = phase_reg;
        code_next  = code_reg;
        cnt_next   = cnt_reg;
        for (int i = 0; i < ARG_KEEP; i++)
        begin
            arg_next[i] = arg_reg[i];
        end

        res_valid = 1'b0;
        res_word  = '{action: ACT_CLR_SCRN, cell_col: 8'd0, cell_row: 8'd0,
                      glyph: 8'd0, glyph_color: 32'd0};

        if (s1_word_reg.op)
        begin
            col_next   = 8'd0;
            row_next   = 16'd0;
            color_next = default_color_reg;
            phase_next = PH_NORMAL;
            res_valid  = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    code_next = b;
                    cnt_next  = '0;
                    for (int i = 0; i < ARG_KEEP; i++)
                    begin
                        arg_next[i] = 8'd0;
                    end
                    if (eob)
                    begin
                        phase_next = PH_NORMAL;
                        run        = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ARGS;
                    end
                end
                PH_ARGS:
                begin
                    store = (b != CH_CMD_END) && (cnt_reg < CNT_W'(MAX_ARGS));
                    if (store)
                    begin
                        for (int i = 0; i < ARG_KEEP; i++)
                        begin
                            if (cnt_reg == CNT_W'(i))
                            begin
                                arg_next[i] = b;
                            end
                        end
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if ((b == CH_CMD_END) || (cnt_next >= CNT_W'(MAX_ARGS)) || eob)
                    begin
                        phase_next = PH_NORMAL;
                        run        = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_NORMAL;
                    if (b == CH_CMD_START)
                    begin
                        if (!eob)
                        begin
                            phase_next = PH_CMD;
                        end
                    end
                    else if (b == CH_NL)
                    begin
                        col_next = 8'd0;
                        row_next = row_sum[16] ? ROW_MAX : row_sum[15:0];
                    end
                    else if (b == CH_CR)
                    begin
                        col_next = 8'd0;
                    end
                    else if (b == CH_TAB)
                    begin
                        if (col_tab >= {1'b0, columns_reg})
                        begin
                            col_next = 8'd0;
                            row_next = row_sum[16] ? ROW_MAX : row_sum[15:0];
                        end
                        else
                        begin
                            col_next = col_tab[7:0];
                        end
                    end
                    else
                    begin
                        if (visible && (col_reg < columns_reg))
                        begin
                            res_valid = 1'b1;
                            res_word  = '{action: ACT_GLYPH, cell_col: col_reg,
                                          cell_row: vrow, glyph: b,
                                          glyph_color: color_reg};
                        end
                        if (col_inc >= {1'b0, columns_reg})
                        begin
                            col_next = 8'd0;
                            row_next = row_sum[16] ? ROW_MAX : row_sum[15:0];
                        end
                        else
                        begin
                            col_next = col_inc[7:0];
                        end
                    end
                end
            endcase

            // command execution on the updated code, count and arguments
            if (run)
            begin
                case (code_next)
                    CMD_COLOR:
                    begin
                        if (cnt_next >= CNT_W'(4))
                        begin
                            color_next = {arg_next[3], arg_next[0], arg_next[1], arg_next[2]};
                        end
                    end
                    CMD_RESET_C:
                    begin
                        color_next = default_color_reg;
                    end
                    CMD_UP:
                    begin
                        if (cnt_next != '0)
                        begin
                            row_next = (row_reg > {8'd0, arg_next[0]})
                                     ? row_reg - {8'd0, arg_next[0]} : 16'd0;
                        end
                    end
                    CMD_DOWN:
                    begin
                        if (cnt_next != '0)
                        begin
                            row_sum  = {1'b0, row_reg} + {9'd0, arg_next[0]};
                            row_next = row_sum[16] ? ROW_MAX : row_sum[15:0];
                        end
                    end
                    CMD_POS:
                    begin
                        if (cnt_next >= CNT_W'(2))
                        begin
                            col_next = arg_next[0];
                            row_next = {8'd0, arg_next[1]};
                        end
                    end
                    CMD_CLR_EOL:
                    begin
                        if (visible && (col_reg < columns_reg))
                        begin
                            res_valid = 1'b1;
                            res_word  = '{action: ACT_CLR_EOL, cell_col: col_reg,
                                          cell_row: vrow, glyph: 8'd0,
                                          glyph_color: 32'd0};
                        end
                    end
                    CMD_CLR_LINE:
                    begin
                        if (visible)
                        begin
                            res_valid = 1'b1;
                            res_word  = '{action: ACT_CLR_LINE, cell_col: 8'd0,
                                          cell_row: vrow, glyph: 8'd0,
                                          glyph_color: 32'd0};
                        end
                        col_next = 8'd0;
                    end
                    CMD_CLR_SCRN:
                    begin
                        res_valid = 1'b1;
                        col_next  = 8'd0;
                        row_next  = scroll_offset_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_clear_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid && (act_data.action != ACT_GLYPH)
        |-> (act_data.glyph == 8'd0) && (act_data.glyph_color == 32'd0))
        else $error("clear word carries glyph data");

    a_frame_resets_parser: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_word_reg.op |=> (phase_reg == PH_NORMAL) && act_valid
            && (act_data.action == ACT_CLR_SCRN))
        else $error("frame start did not reset parser");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ARGS))
        else $error("argument count overflow");

    a_glyph_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid && (act_data.action == ACT_GLYPH)
        |-> (act_data.cell_col < columns_reg) && (act_data.cell_row < rows_reg))
        else $error("glyph outside visible window");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> text_ready)
        else $error("input stalled with empty input register");
`endif

endmodule

/* tb/sv/text_console_command_parser_unit_test.sv */
// self-checking testbench for the text console command parser unit
module text_console_command_parser_unit_test;
    import tccp_pkg::*;

    localparam int ARG_SLOTS  = 8;
    localparam int IDLE_LIMIT = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        text_valid = 1'b0;
    logic        text_ready;
    in_word_t    text_data = '0;
    logic        act_valid;
    logic        act_ready = 1'b0;
    out_word_t   act_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // console model state
    logic [31:0] m_default_color = COLOR_INIT;
    logic [7:0]  m_columns = 8'd80;
    logic [7:0]  m_rows = 8'd25;
    logic [15:0] m_scroll = 16'd0;
    logic [7:0]  cur_col = 8'd0;
    logic [15:0] cur_row = 16'd0;
    logic [31:0] cur_color = COLOR_INIT;
    phase_t      parse_ph = PH_NORMAL;
    logic [7:0]  cmd_code = 8'd0;
    logic [7:0]  arg_vals [ARG_SLOTS];
    int          arg_n = 0;

    in_word_t    text_words [$];
    out_word_t   expected_acts [$];
    out_word_t   pred;
    out_word_t   want;
    int          gap_left = 0;
    int          stall_left = 0;
    int          words_in = 0;
    int          errors = 0;
    int          idle_cycles = 0;
    bit          gapless = 1'b0;
    bit          long_hold_done = 1'b0;

    text_console_command_parser_unit #(.MAX_ARGS(ARG_SLOTS)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_data  (text_data),
        .act_valid  (act_valid),
        .act_ready  (act_ready),
        .act_data   (act_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic out_word_t make_act(action_t a, logic [7:0] col, logic [7:0] row,
                                           logic [7:0] g, logic [31:0] color);
        out_word_t w;
        w.action = a;
        w.cell_col = col;
        w.cell_row = row;
        w.glyph = g;
        w.glyph_color = color;
        return w;
    endfunction

    function automatic void bump_row(int n);
        int t;
        t = int'(cur_row) + n;
        cur_row = (t > int'(ROW_MAX)) ? ROW_MAX : t[15:0];
    endfunction

    function automatic bit row_shown();
        return cur_row >= m_scroll && int'(cur_row) - int'(m_scroll) < int'(m_rows);
    endfunction

    function automatic logic [7:0] vis_row();
        logic [15:0] d;
        d = cur_row - m_scroll;
        return d[7:0];
    endfunction

    function automatic void set_col(int nxt);
        if (nxt >= int'(m_columns))
        begin
            cur_col = 8'd0;
            bump_row(1);
        end
        else
            cur_col = nxt[7:0];
    endfunction

    function automatic bit run_console_cmd(output out_word_t r);
        bit hit;
        hit = 1'b0;
        r = '0;
        case (cmd_code)
            CMD_COLOR:
                if (arg_n >= 4)
                    cur_color = {arg_vals[3], arg_vals[0], arg_vals[1], arg_vals[2]};
            CMD_RESET_C:
                cur_color = m_default_color;
            CMD_UP:
                if (arg_n >= 1)
                    cur_row = (cur_row > {8'd0, arg_vals[0]})
                            ? cur_row - {8'd0, arg_vals[0]} : 16'd0;
            CMD_DOWN:
                if (arg_n >= 1)
                    bump_row(int'(arg_vals[0]));
            CMD_POS:
                if (arg_n >= 2)
                begin
                    cur_col = arg_vals[0];
                    cur_row = {8'd0, arg_vals[1]};
                end
            CMD_CLR_EOL:
                if (row_shown() && cur_col < m_columns)
                begin
                    r = make_act(ACT_CLR_EOL, cur_col, vis_row(), 8'd0, 32'd0);
                    hit = 1'b1;
                end
            CMD_CLR_LINE:
            begin
                if (row_shown())
                begin
                    r = make_act(ACT_CLR_LINE, 8'd0, vis_row(), 8'd0, 32'd0);
                    hit = 1'b1;
                end
                cur_col = 8'd0;
            end
            CMD_CLR_SCRN:
            begin
                r = make_act(ACT_CLR_SCRN, 8'd0, 8'd0, 8'd0, 32'd0);
                hit = 1'b1;
                cur_col = 8'd0;
                cur_row = m_scroll;
            end
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic bit console_step(input in_word_t w, output out_word_t r);
        bit         hit;
        logic [7:0] b;
        hit = 1'b0;
        r = '0;
        b = w.text_byte;
        if (w.op)
        begin
            cur_col = 8'd0;
            cur_row = 16'd0;
            cur_color = m_default_color;
            parse_ph = PH_NORMAL;
            r = make_act(ACT_CLR_SCRN, 8'd0, 8'd0, 8'd0, 32'd0);
            return 1'b1;
        end
        case (parse_ph)
            PH_CMD:
            begin
                cmd_code = b;
                arg_n = 0;
                for (int i = 0; i < ARG_SLOTS; i++)
                    arg_vals[i] = 8'd0;
                if (w.end_of_buffer)
                begin
                    parse_ph = PH_NORMAL;
                    hit = run_console_cmd(r);
                end
                else
                    parse_ph = PH_ARGS;
            end
            PH_ARGS:
            begin
                if (b != CH_CMD_END && arg_n < ARG_SLOTS)
                begin
                    arg_vals[arg_n] = b;
                    arg_n++;
                end
                if (b == CH_CMD_END || arg_n >= ARG_SLOTS || w.end_of_buffer)
                begin
                    parse_ph = PH_NORMAL;
                    hit = run_console_cmd(r);
                end
            end
            default:
            begin
                parse_ph = PH_NORMAL;
                if (b == CH_CMD_START)
                begin
                    if (!w.end_of_buffer)
                        parse_ph = PH_CMD;
                end
                else if (b == CH_NL)
                begin
                    cur_col = 8'd0;
                    bump_row(1);
                end
                else if (b == CH_CR)
                    cur_col = 8'd0;
                else if (b == CH_TAB)
                    set_col((int'(cur_col) + 8) & ~7);
                else
                begin
                    if (row_shown() && cur_col < m_columns)
                    begin
                        r = make_act(ACT_GLYPH, cur_col, vis_row(), b, cur_color);
                        hit = 1'b1;
                    end
                    set_col(int'(cur_col) + 1);
                end
            end
        endcase
        return hit;
    endfunction

    function automatic int pick_gap();
        int r;
        if (gapless)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_word(bit op, logic [7:0] b, bit eob);
        in_word_t w;
        w.op = op;
        w.text_byte = b;
        w.end_of_buffer = eob;
        text_words.push_back(w);
    endtask

    // eob on the last byte, or a terminator after the arguments
    task automatic add_cmd(logic [7:0] code, int n, logic [7:0] a0, logic [7:0] a1,
                           bit use_eob);
        add_word(1'b0, CH_CMD_START, 1'b0);
        add_word(1'b0, code, use_eob && n == 0);
        if (n > 0)
            add_word(1'b0, a0, use_eob && n == 1);
        if (n > 1)
            add_word(1'b0, a1, use_eob);
        if (!use_eob)
            add_word(1'b0, CH_CMD_END, 1'b0);
    endtask

    task automatic add_random_cmd();
        logic [7:0] code;
        logic [7:0] a;
        int         nargs;
        int         ending;
        case ($urandom_range(0, 9))
            0: code = CMD_COLOR;
            1: code = CMD_RESET_C;
            2: code = CMD_UP;
            3: code = CMD_DOWN;
            4: code = CMD_POS;
            5: code = CMD_CLR_EOL;
            6: code = CMD_CLR_LINE;
            7: code = CMD_CLR_SCRN;
            default: code = 8'($urandom_range(0, 255));
        endcase
        nargs = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, ARG_SLOTS);
        ending = $urandom_range(0, 3);
        add_word(1'b0, CH_CMD_START, 1'b0);
        add_word(1'b0, code, nargs == 0 && ending == 0);
        for (int i = 0; i < nargs; i++)
        begin
            a = 8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255));
            add_word(1'b0, a, i == nargs - 1 && ending == 0);
        end
        if (ending != 0 && (nargs < ARG_SLOTS || $urandom_range(0, 1)))
            add_word(1'b0, CH_CMD_END, 1'b0);
    endtask

    task automatic add_random_unit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            add_word(1'b0, 8'($urandom_range(32, 126)), $urandom_range(0, 9) == 0);
        else if (r < 50)
            add_word(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else if (r < 60)
            case ($urandom_range(0, 2))
                0: add_word(1'b0, CH_NL, 1'b0);
                1: add_word(1'b0, CH_CR, 1'b0);
                default: add_word(1'b0, CH_TAB, 1'b0);
            endcase
        else if (r < 88)
            add_random_cmd();
        else if (r < 92)
            add_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
            case ($urandom_range(0, 2))
                0: add_word(1'b0, CH_CMD_START, 1'b1);
                1: add_word(1'b0, CH_CMD_END, 1'($urandom_range(0, 1)));
                default: add_word(1'b0, CH_CMD_START, 1'b0);
            endcase
    endtask

    task automatic add_random(int n);
        int target;
        target = text_words.size() + n;
        while (text_words.size() < target)
            add_random_unit();
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_DEFAULT_COLOR: m_default_color = value;
            REG_COLUMNS: m_columns = value[7:0];
            REG_ROWS: m_rows = value[7:0];
            default: m_scroll = value[15:0];
        endcase
    endtask

    task automatic write_geometry(logic [31:0] color, logic [7:0] cols, logic [7:0] nrows,
                                  logic [15:0] scroll);
        write_reg(REG_DEFAULT_COLOR, color);
        write_reg(REG_COLUMNS, {24'd0, cols});
        write_reg(REG_ROWS, {24'd0, nrows});
        write_reg(REG_SCROLL_OFFSET, {16'd0, scroll});
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // wait for every word to go in and every result to come out
    task automatic settle();
        while (text_words.size() != 0 || text_valid || expected_acts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            text_data <= '0;
            gap_left = 0;
        end
        else
        begin
            if (text_valid && text_ready)
            begin
                words_in++;
                if (console_step(text_data, pred))
                    expected_acts.push_back(pred);
            end
            if (!text_valid || text_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    text_valid <= 1'b0;
                end
                else if (text_words.size() != 0)
                begin
                    text_data <= text_words.pop_front();
                    text_valid <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                    text_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (act_valid && act_ready)
            begin
                if (expected_acts.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no word actual %0d/%0d/%0d/%h/%h", $time,
                             act_data.action, act_data.cell_col, act_data.cell_row,
                             act_data.glyph, act_data.glyph_color);
                end
                else
                begin
                    want = expected_acts.pop_front();
                    if (act_data !== want)
                    begin
                        errors++;
                        $display("%0t: expected %0d/%0d/%0d/%h/%h actual %0d/%0d/%0d/%h/%h",
                                 $time, want.action, want.cell_col, want.cell_row,
                                 want.glyph, want.glyph_color, act_data.action,
                                 act_data.cell_col, act_data.cell_row, act_data.glyph,
                                 act_data.glyph_color);
                    end
                end
            end
            // one long hold so the unit backs up into its input
            if (!long_hold_done && words_in >= 300)
            begin
                long_hold_done = 1'b1;
                stall_left = 200;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                act_ready <= 1'b0;
            end
            else
            begin
                act_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_valid && text_ready) || (act_valid && act_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < ARG_SLOTS; i++)
            arg_vals[i] = 8'd0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_geometry(COLOR_INIT, 8'd80, 8'd25, 16'd0);
        add_word(1'b1, 8'hff, 1'b1);
        add_word(1'b0, 8'h00, 1'b1);
        add_word(1'b0, 8'hff, 1'b0);
        add_word(1'b0, CH_TAB, 1'b0);
        add_word(1'b0, CH_CR, 1'b0);
        add_word(1'b0, CH_NL, 1'b0);
        // full argument list, the trailing terminator prints as text
        add_word(1'b0, CH_CMD_START, 1'b0);
        add_word(1'b0, CMD_COLOR, 1'b0);
        for (int i = 0; i < ARG_SLOTS; i++)
            add_word(1'b0, 8'(8'h11 * (i + 1)), 1'b0);
        add_word(1'b0, CH_CMD_END, 1'b0);
        add_cmd(CMD_RESET_C, 0, 8'd0, 8'd0, 1'b1);
        add_cmd(CMD_POS, 2, 8'd200, 8'd1, 1'b0);
        add_word(1'b0, "C", 1'b0);
        add_cmd(CMD_UP, 1, 8'd1, 8'd0, 1'b1);
        add_cmd(CMD_CLR_EOL, 0, 8'd0, 8'd0, 1'b1);
        add_cmd(CMD_CLR_LINE, 0, 8'd0, 8'd0, 1'b1);
        add_cmd(CMD_CLR_SCRN, 0, 8'd0, 8'd0, 1'b1);
        add_word(1'b0, CH_CMD_START, 1'b1);
        settle();

        gapless = 1'b1;
        write_geometry(COLOR_INIT, 8'd80, 8'd25, 16'd0);
        add_random(200);
        settle();
        gapless = 1'b0;

        write_geometry(32'd0, 8'd255, 8'd255, 16'd0);
        add_random(150);
        settle();

        write_geometry($urandom, 8'd1, 8'd1, 16'd0);
        add_random(120);
        settle();

        write_geometry($urandom, 8'($urandom_range(8, 40)), 8'($urandom_range(4, 12)),
                       16'($urandom_range(1, 6)));
        add_random(200);
        settle();

        // zero geometry
        write_geometry($urandom, 8'd0, 8'd25, 16'd0);
        add_random(60);
        settle();

        write_geometry($urandom, 8'd80, 8'd0, 16'd0);
        add_random(60);
        settle();

        write_geometry($urandom, 8'd255, 8'd255, 16'hffff);
        add_random(60);
        settle();

        write_geometry($urandom, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                       16'($urandom_range(0, 20)));
        add_random(250);
        settle();

        // clear screen puts the cursor at the scroll offset, then climb to the row limit
        write_geometry($urandom, 8'd80, 8'd10, 16'd65530);
        add_cmd(CMD_CLR_SCRN, 0, 8'd0, 8'd0, 1'b1);
        add_word(1'b0, "V", 1'b0);
        for (int i = 0; i < 2; i++)
            add_cmd(CMD_DOWN, 1, 8'hff, 8'd0, 1'b1);
        add_word(1'b0, "X", 1'b0);
        add_word(1'b0, CH_NL, 1'b0);
        add_word(1'b0, "Y", 1'b0);
        add_cmd(CMD_DOWN, 1, 8'd5, 8'd0, 1'b0);
        add_word(1'b0, "Z", 1'b0);
        add_cmd(CMD_CLR_EOL, 0, 8'd0, 8'd0, 1'b1);
        add_cmd(CMD_CLR_LINE, 0, 8'd0, 8'd0, 1'b0);
        add_cmd(CMD_UP, 1, 8'd3, 8'd0, 1'b1);
        add_word(1'b0, "W", 1'b0);
        settle();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
src/tccp_pkg.sv
src/text_console_command_parser_unit.sv
tb/sv/text_console_command_parser_unit_test.sv
